[hw/rtl/tkrs_pkg.sv]
// ----------------------------------------------------------------------------
// Tracker row sequencer package
// Shared constants, command codes and structure types of the row sequencer.
// ----------------------------------------------------------------------------
package tkrs_pkg;

   // Default sizes of the song structure.
   localparam int ROWS_PER_PATTERN_DEF = 64;
   localparam int ORDER_DEPTH_DEF      = 256;
   localparam int TRACKS               = 4;

   // Special codes in the song data.
   localparam logic [15:0] END_MARK     = 16'hFFFF;
   localparam logic [6:0]  MUTE_CODE    = 7'h7F;
   localparam logic [4:0]  DATA_MASK    = 5'h1F;
   localparam logic [2:0]  SPEED_EFFECT = 3'd7;

   // Byte slot codes: the bitmap is awaited, or no further byte is present.
   localparam logic [3:0] SLOT_BITMAP = 4'd0;
   localparam logic [3:0] SLOT_NONE   = 4'd8;

   // Input commands.
   typedef enum logic [1:0] {
      CMD_TICK  = 2'd0,
      CMD_BYTE  = 2'd1,
      CMD_WRITE = 2'd2
   } command_type;

   // The four 16-bit track words of one row.
   typedef logic [TRACKS-1:0][15:0] words_type;

   // Status of one row byte as seen by the unpacker.
   typedef struct packed {
      logic       finish;
      logic [3:0] slot;
      logic       speed_we;
      logic [4:0] speed;
   } row_status_type;

   // One result transaction.
   typedef struct packed {
      logic        is_channel_update;
      logic        row_due;
      logic [15:0] fetch_address;
      logic [7:0]  pattern_index;
      logic [5:0]  row_position;
      logic [1:0]  channel;
      logic        note_valid;
      logic [6:0]  note;
      logic        last;
   } result_type;

endpackage

[hw/rtl/tracker_row_sequencer_core.sv]
// ----------------------------------------------------------------------------
// Tracker row sequencer core
// Divides ticks by the song speed, steps rows and patterns through the
// pattern order table, and rebuilds compressed rows into per-track notes.
//
//   Channel | Direction | Handshake         | Payload
//   req_    | in        | req_valid/stall   | command, byte, order index/value
//   rsp_    | out       | rsp_valid/stall   | tick report or track result
//
// One transaction is accepted per cycle while req_stall is low. A tick that may
// advance the pattern uses the order table entry prefetched from the RAM, so a
// tick is held after a table write or a pattern advance until the registered
// RAM read gives the new entry. A completed row yields four results, one per
// track; ticks and row bytes are held meanwhile, table writes are still taken.
// A tick also waits while the output register is full and stalled. Reset is
// synchronous; the order table holds no reset value and needs no clearing pass.
// ----------------------------------------------------------------------------
module tracker_row_sequencer_core #(
   parameter int ROWS_PER_PATTERN = tkrs_pkg::ROWS_PER_PATTERN_DEF,
   parameter int ORDER_DEPTH      = tkrs_pkg::ORDER_DEPTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_command,
   input  logic [7:0]  req_byte_value,
   input  logic [7:0]  req_order_index,
   input  logic [15:0] req_order_value,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_is_channel_update,
   output logic        rsp_row_due,
   output logic [15:0] rsp_fetch_address,
   output logic [7:0]  rsp_pattern_index,
   output logic [5:0]  rsp_row_position,
   output logic [1:0]  rsp_channel,
   output logic        rsp_note_valid,
   output logic [6:0]  rsp_note,
   output logic        rsp_last
);

   localparam int OAW = $clog2(ORDER_DEPTH);

   // Sequencer state.
   logic [4:0]          speed_ff, speed_in;
   logic [4:0]          tick_count_ff, tick_count_in;
   logic [6:0]          row_counter_ff, row_counter_in;
   logic [OAW-1:0]      order_pos_ff, order_pos_in;
   logic [15:0]         read_ptr_ff, read_ptr_in;
   logic [7:0]          presence_ff, presence_in;
   logic [3:0]          slot_ff, slot_in;
   logic                row_exp_ff, row_exp_in;
   tkrs_pkg::words_type words_ff, words_in;
   logic                prefetch_ok_ff, prefetch_ok_in;
   logic                drain_ff, drain_in;
   logic [1:0]          drain_ch_ff, drain_ch_in;
   logic                rsp_valid_ff, rsp_valid_in;
   tkrs_pkg::result_type rsp_ff, rsp_in;

   // Decode and handshake.
   logic                    is_tick, is_byte, is_write;
   logic                    slot_free, accept;
   logic [OAW-1:0]          next_op;
   logic [15:0]             entry;
   logic                    end_hit;
   logic [5:0]              tick_next;
   logic                    row_step;
   logic [7:0]              row_inc;
   logic                    wrap;
   logic                    wr_en;
   logic [7:0]              unpack_presence;
   tkrs_pkg::words_type     unpack_words;
   tkrs_pkg::row_status_type unpack_status;
   logic [15:0]             drain_word;
   logic [6:0]              drain_note;

   assign is_tick  = (req_command == tkrs_pkg::CMD_TICK);
   assign is_byte  = (req_command == tkrs_pkg::CMD_BYTE);
   assign is_write = (req_command == tkrs_pkg::CMD_WRITE);

   assign slot_free = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (is_tick && (drain_ff || !slot_free || !prefetch_ok_ff)) ||
                      (is_byte && drain_ff);
   assign accept    = req_valid && !req_stall;

   // Order table: the entry after the current position is read continuously.
   assign next_op = (order_pos_ff == OAW'(ORDER_DEPTH - 1)) ? '0 : order_pos_ff + OAW'(1);
   assign wr_en   = accept && is_write && ({1'b0, req_order_index} < 9'(ORDER_DEPTH));

   tkrs_ram #(
      .WIDTH (16),
      .DEPTH (ORDER_DEPTH)
   ) u_order_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (req_order_index[OAW-1:0]),
      .wr_data (req_order_value),
      .rd_addr (next_op),
      .rd_data (entry)
   );

   assign end_hit = (entry == tkrs_pkg::END_MARK);

   // Tick division and row stepping.
   assign tick_next = {1'b0, tick_count_ff} + 6'd1;
   assign row_step  = (tick_next >= {1'b0, speed_ff});
   assign row_inc   = {1'b0, row_counter_ff} + 8'd1;
   assign wrap      = (row_inc >= 8'(ROWS_PER_PATTERN));

   // Row byte unpacking.
   tkrs_row_unpack u_row_unpack (
      .byte_value    (req_byte_value),
      .slot          (slot_ff),
      .presence      (presence_ff),
      .words         (words_ff),
      .presence_next (unpack_presence),
      .words_next    (unpack_words),
      .status        (unpack_status)
   );

   // Track result decode for the channel being drained.
   assign drain_word = words_ff[drain_ch_ff];
   assign drain_note = drain_word[15:9];

   // Next state of the sequencer and the output register.
   always_comb begin
      speed_in       = speed_ff;
      tick_count_in  = tick_count_ff;
      row_counter_in = row_counter_ff;
      order_pos_in   = order_pos_ff;
      read_ptr_in    = read_ptr_ff;
      presence_in    = presence_ff;
      slot_in        = slot_ff;
      row_exp_in     = row_exp_ff;
      words_in       = words_ff;
      drain_in       = drain_ff;
      drain_ch_in    = drain_ch_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_in         = rsp_ff;
      prefetch_ok_in = 1'b1;

      if (accept && is_write) begin
         prefetch_ok_in = 1'b0;
      end

      // Tick transaction: one report.
      if (accept && is_tick) begin
         if (!row_step) begin
            tick_count_in = tick_next[4:0];
         end else begin
            tick_count_in = '0;
            if (wrap) begin
               row_counter_in = '0;
               order_pos_in   = end_hit ? '0 : next_op;
               read_ptr_in    = end_hit ? '0 : entry;
               prefetch_ok_in = 1'b0;
            end else begin
               row_counter_in = row_inc[6:0];
            end
            row_exp_in = 1'b1;
            slot_in    = tkrs_pkg::SLOT_BITMAP;
         end
         rsp_valid_in             = 1'b1;
         rsp_in                   = '0;
         rsp_in.row_due           = row_step;
         rsp_in.fetch_address     = row_step ? read_ptr_in : '0;
         rsp_in.pattern_index     = 8'(order_pos_in);
         rsp_in.row_position      = row_counter_in[5:0];
      end

      // Row byte transaction.
      if (accept && is_byte && row_exp_ff) begin
         read_ptr_in = read_ptr_ff + 16'd1;
         presence_in = unpack_presence;
         words_in    = unpack_words;
         slot_in     = unpack_status.slot;
         if (unpack_status.finish) begin
            row_exp_in  = 1'b0;
            drain_in    = 1'b1;
            drain_ch_in = '0;
            if (unpack_status.speed_we) begin
               speed_in = unpack_status.speed;
            end
         end
      end

      // Drain of the completed row, one track per cycle while the output register is free.
      if (drain_ff && slot_free) begin
         rsp_valid_in             = 1'b1;
         rsp_in                   = '0;
         rsp_in.is_channel_update = 1'b1;
         rsp_in.pattern_index     = 8'(order_pos_ff);
         rsp_in.row_position      = row_counter_ff[5:0];
         rsp_in.channel           = drain_ch_ff;
         rsp_in.note_valid        = (drain_note != '0);
         rsp_in.note              = (drain_note == tkrs_pkg::MUTE_CODE) ? '0 : drain_note;
         rsp_in.last              = (drain_ch_ff == 2'(tkrs_pkg::TRACKS - 1));
         drain_ch_in              = drain_ch_ff + 2'd1;
         if (drain_ch_ff == 2'(tkrs_pkg::TRACKS - 1)) begin
            drain_in = 1'b0;
         end
      end
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         speed_ff       <= 5'd1;
         tick_count_ff  <= '0;
         row_counter_ff <= 7'(ROWS_PER_PATTERN - 1);
         order_pos_ff   <= OAW'(ORDER_DEPTH - 1);
         read_ptr_ff    <= '0;
         presence_ff    <= '0;
         slot_ff        <= tkrs_pkg::SLOT_BITMAP;
         row_exp_ff     <= 1'b0;
         words_ff       <= '0;
         prefetch_ok_ff <= 1'b0;
         drain_ff       <= 1'b0;
         drain_ch_ff    <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         speed_ff       <= speed_in;
         tick_count_ff  <= tick_count_in;
         row_counter_ff <= row_counter_in;
         order_pos_ff   <= order_pos_in;
         read_ptr_ff    <= read_ptr_in;
         presence_ff    <= presence_in;
         slot_ff        <= slot_in;
         row_exp_ff     <= row_exp_in;
         words_ff       <= words_in;
         prefetch_ok_ff <= prefetch_ok_in;
         drain_ff       <= drain_in;
         drain_ch_ff    <= drain_ch_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // Output payload register.
   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_is_channel_update = rsp_ff.is_channel_update;
   assign rsp_row_due           = rsp_ff.row_due;
   assign rsp_fetch_address     = rsp_ff.fetch_address;
   assign rsp_pattern_index     = rsp_ff.pattern_index;
   assign rsp_row_position      = rsp_ff.row_position;
   assign rsp_channel           = rsp_ff.channel;
   assign rsp_note_valid        = rsp_ff.note_valid;
   assign rsp_note              = rsp_ff.note;
   assign rsp_last              = rsp_ff.last;

`ifndef SYNTHESIS
   // A tick is only taken when the prefetched table entry is current.
   a_tick_prefetch: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && is_tick) |-> prefetch_ok_ff)
      else $error("tick accepted with a stale order table entry");

   // While a row drains, neither ticks nor row bytes are taken.
   a_drain_hold: assert property (@(posedge clock) disable iff (reset)
      (drain_ff && req_valid && !req_stall) |-> (!is_tick && !is_byte))
      else $error("tick or row byte accepted during row drain");

   // A track result other than the last one leaves the drain running.
   a_drain_open: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.is_channel_update && !rsp_ff.last) |-> drain_ff)
      else $error("row drain ended before the last track");

   // The last flag marks exactly the final track.
   a_last_track: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.is_channel_update) |->
      (rsp_ff.last == (rsp_ff.channel == 2'(tkrs_pkg::TRACKS - 1))))
      else $error("last flag does not match the final track");

   // The byte slot never passes the end of the bitmap.
   a_slot_range: assert property (@(posedge clock) disable iff (reset)
      slot_ff <= tkrs_pkg::SLOT_NONE)
      else $error("byte slot out of range");
`endif

endmodule

[hw/rtl/tkrs_ram.sv]
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port; read data is registered.
// A read of the address being written returns the old contents.
// ----------------------------------------------------------------------------
module tkrs_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Storage array with a registered read.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[hw/rtl/tkrs_row_unpack.sv]
// ----------------------------------------------------------------------------
// Row byte unpacker
// Merges one compressed row byte into the track words, finds the next present
// byte of the bitmap and works out the speed effect when the row is complete.
// ----------------------------------------------------------------------------
module tkrs_row_unpack (
   input  logic [7:0]               byte_value,
   input  logic [3:0]               slot,
   input  logic [7:0]               presence,
   input  tkrs_pkg::words_type      words,
   output logic [7:0]               presence_next,
   output tkrs_pkg::words_type      words_next,
   output tkrs_pkg::row_status_type status
);

   logic [2:0] byte_pos;
   logic [3:0] next_pos;

   // Lowest set bit of the bitmap at or above the start position.
   function automatic logic [3:0] next_present(input logic [7:0] bits,
                                               input logic [3:0] from);
      logic [3:0] pos;
      pos = tkrs_pkg::SLOT_NONE;
      for (int i = 7; i >= 0; i--) begin
         if (bits[i] && (4'(i) >= from)) begin
            pos = 4'(i);
         end
      end
      return pos;
   endfunction

   // Merge the byte and locate the next one.
   always_comb begin
      words_next    = words;
      presence_next = presence;
      byte_pos      = '0;
      if (slot == tkrs_pkg::SLOT_BITMAP) begin
         presence_next = byte_value;
         words_next    = '0;
         next_pos      = next_present(byte_value, 4'd0);
      end else begin
         byte_pos = 3'(slot - 4'd1);
         if (byte_pos[0]) begin
            words_next[byte_pos[2:1]] = words[byte_pos[2:1]] | {8'h00, byte_value};
         end else begin
            words_next[byte_pos[2:1]] = {byte_value, 8'h00};
         end
         next_pos = next_present(presence, {1'b0, byte_pos} + 4'd1);
      end
   end

   // Row completion and speed effect; a later track overrides an earlier one.
   always_comb begin
      status.finish   = (next_pos == tkrs_pkg::SLOT_NONE);
      status.slot     = status.finish ? tkrs_pkg::SLOT_BITMAP : next_pos + 4'd1;
      status.speed_we = 1'b0;
      status.speed    = '0;
      for (int t = 0; t < tkrs_pkg::TRACKS; t++) begin
         if (words_next[t][8:6] == tkrs_pkg::SPEED_EFFECT) begin
            status.speed_we = 1'b1;
            status.speed    = words_next[t][4:0] & tkrs_pkg::DATA_MASK;
         end
      end
   end

endmodule
